// ===== hw/rtl/tbrl_pkg.sv =====
// Shared types and constants for the token bucket rate limiter.
package tbrl_pkg;

  // Field widths
  localparam int CLIENT_W = 8;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 16;
  localparam int MILLI_W  = 26;
  localparam int COUNT_W  = 32;
  localparam int PROD_W   = TIME_W + CFG_W;
  localparam int SUM_W    = PROD_W + 1;

  // Stream and configuration port widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 2;

  // Table depth default
  localparam int CLIENT_ENTRIES_DEF = 256;

  // One token in milli-tokens
  localparam logic [9:0] MILLI_PER_TOKEN = 10'd1000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] RATE_RST  = 16'd10;
  localparam logic [CFG_W-1:0] BURST_RST = 16'd20;
  localparam logic [CFG_W-1:0] BLOCK_RST = 16'd0;

  // One bucket table entry
  typedef struct packed {
    logic               valid;
    logic [MILLI_W-1:0] milli;
    logic [TIME_W-1:0]  last_ms;
    logic               blk_active;
    logic [TIME_W-1:0]  blk_end;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;
    logic load_in;
    logic mem_rd;
    logic mul_en;
    logic lvl_en;
    logic upd_en;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic out_stall;
  } stat_t;

endpackage

// ===== hw/rtl/token_bucket_rate_limiter.sv =====
// Top level of the per-client token bucket rate limiter with penalty block.
//
// Usage: each word on the in_ stream carries a client index and the current time
// in ms. The block refills that client's bucket by the elapsed time, checks for a
// running penalty block, spends one token or refuses, and returns one word on the
// out_ stream: the decision and the saturating admitted and refused totals.
// Configuration (rate, burst size, block length) is written on the cfg_ channel,
// which is always ready; write it only while no request is in flight.
// Each word passes the read, multiply, level and update steps of the read-modify-write
// of the single-port bucket table before out_tvalid rises; the next word is accepted
// only once the previous word's update is done.
// Reset: totals clear and a clearing pass walks the bucket table one entry per
// cycle over all CLIENT_ENTRIES entries (256 by default), with in_tready low throughout.
// Stall: a finished result waits in the output register; the next word is still
// accepted and processed, and its update waits until the held result is taken.
module token_bucket_rate_limiter
  import tbrl_pkg::*;
#(
  parameter int CLIENT_ENTRIES = CLIENT_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // client_index[7:0], now_ms[39:8]
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // allowed[0], allowed_total[32:1],
                                            // refused_total[64:33], zero pad[71:65]
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cmd_t  cmd;
  stat_t st;

  tbrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tbrl_dp #(
    .CLIENT_ENTRIES (CLIENT_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // One word in flight: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in flight");

  // Admitted total never decreases
  a_allowed_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> out_tdata[32:1] >= $past(out_tdata[32:1]))
    else $error("admitted total decreased");

  // An admit result carries a nonzero admitted total
  a_admit_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[32:1] != 32'd0)
    else $error("admit reported with zero admitted total");

  // Table update never happens during the clearing pass
  a_no_upd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !cmd.upd_en && !in_tready)
    else $error("update or accept during table clearing");

endmodule

// ===== hw/rtl/tbrl_ctrl.sv =====
// Controller state machine: table clearing pass and per-word sequencing.
module tbrl_ctrl
  import tbrl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_MUL,
    S_LVL,
    S_UPD
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  assign in_tready = in_ready_r;

  // Decode commands from state
  always_comb begin
    cmd         = '0;
    cmd.clr_wr  = (state_r == S_CLR);
    cmd.load_in = in_tvalid && in_ready_r;
    cmd.mem_rd  = (state_r == S_RD);
    cmd.mul_en  = (state_r == S_MUL);
    cmd.lvl_en  = (state_r == S_LVL);
    cmd.upd_en  = (state_r == S_UPD) && !st.out_stall;
  end

  // Hold state and the input ready flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      in_ready_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLR: begin
          if (st.clr_last) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_tvalid && in_ready_r) begin
            state_r    <= S_RD;
            in_ready_r <= 1'b0;
          end
        end
        S_RD:  state_r <= S_MUL;
        S_MUL: state_r <= S_LVL;
        S_LVL: state_r <= S_UPD;
        S_UPD: begin
          if (!st.out_stall) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_CLR;
          in_ready_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/tbrl_dp.sv =====
// Datapath: config registers, bucket table, refill and decision logic, result register.
module tbrl_dp
  import tbrl_pkg::*;
#(
  parameter int CLIENT_ENTRIES = CLIENT_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 st,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CLIENT_ENTRIES - 1);
  localparam int CLIENT_SPAN = 1 << CLIENT_W;

  // Configuration and derived scaled values
  logic [CFG_W-1:0]   rate_r;
  logic [MILLI_W-1:0] cap_r;
  logic [MILLI_W-1:0] blk_ms_r;

  // Bucket table
  entry_t mem [CLIENT_ENTRIES];
  logic [IDX_W-1:0] clr_cnt_r;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             wr_en;

  // Client index folded into the table depth
  logic [IDX_W-1:0] idx_lut [CLIENT_SPAN];

  // Per-word pipeline registers
  logic [IDX_W-1:0]   idx_r;
  logic [TIME_W-1:0]  now_r;
  entry_t             rd_r;
  logic [PROD_W-1:0]  prod_r;
  logic [MILLI_W-1:0] lvl_r;
  logic               blocked_r;

  // Totals and result register
  logic               out_valid_r;
  logic               out_allowed_r;
  logic [COUNT_W-1:0] allowed_total_r;
  logic [COUNT_W-1:0] refused_total_r;

  logic [TIME_W-1:0]  elapsed;
  logic [SUM_W-1:0]   sum;
  logic [TIME_W-1:0]  blk_diff;
  logic               admit;
  entry_t             upd_entry;

  assign cfg_ready    = 1'b1;
  assign st.clr_last  = (clr_cnt_r == IDX_LAST);
  assign st.out_stall = out_valid_r && !out_tready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= RATE_RST;
      cap_r    <= MILLI_W'(BURST_RST) * MILLI_W'(MILLI_PER_TOKEN);
      blk_ms_r <= MILLI_W'(BLOCK_RST) * MILLI_W'(MILLI_PER_TOKEN);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RATE:  rate_r   <= cfg_data;
        REG_BURST: cap_r    <= MILLI_W'(cfg_data) * MILLI_W'(MILLI_PER_TOKEN);
        REG_BLOCK: blk_ms_r <= MILLI_W'(cfg_data) * MILLI_W'(MILLI_PER_TOKEN);
        default: ;
      endcase
    end
  end

  // Advance the clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr && !st.clr_last) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Constant table: client index modulo the table depth
  for (genvar g = 0; g < CLIENT_SPAN; g++) begin : g_idx_lut
    assign idx_lut[g] = IDX_W'(g % CLIENT_ENTRIES);
  end

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      idx_r <= idx_lut[in_tdata[CLIENT_W-1:0]];
      now_r <= in_tdata[CLIENT_W +: TIME_W];
    end
  end

  // Table write port mux
  always_comb begin
    wr_en   = cmd.clr_wr || cmd.upd_en;
    wr_addr = cmd.clr_wr ? clr_cnt_r : idx_r;
    wr_data = cmd.clr_wr ? entry_t'('0) : upd_entry;
  end

  // Bucket table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[idx_r];
    end
  end

  // Refill amount: elapsed ms times rate
  assign elapsed = now_r - rd_r.last_ms;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(elapsed) * PROD_W'(rate_r);
    end
  end

  // Capped bucket level and block test
  assign sum      = {{(SUM_W-MILLI_W){1'b0}}, rd_r.milli} + {1'b0, prod_r};
  assign blk_diff = now_r - rd_r.blk_end;

  always_ff @(posedge clk) begin
    if (cmd.lvl_en) begin
      if (!rd_r.valid || (sum > {{(SUM_W-MILLI_W){1'b0}}, cap_r})) begin
        lvl_r <= cap_r;
      end else begin
        lvl_r <= sum[MILLI_W-1:0];
      end
      blocked_r <= rd_r.valid && rd_r.blk_active && blk_diff[TIME_W-1];
    end
  end

  // Decide and build the updated entry
  always_comb begin
    admit                = !blocked_r && (lvl_r >= MILLI_W'(MILLI_PER_TOKEN));
    upd_entry.valid      = 1'b1;
    upd_entry.last_ms    = now_r;
    upd_entry.milli      = lvl_r;
    upd_entry.blk_active = 1'b0;
    upd_entry.blk_end    = rd_r.valid ? rd_r.blk_end : '0;
    if (blocked_r) begin
      upd_entry.blk_active = 1'b1;
    end else if (admit) begin
      upd_entry.milli = lvl_r - MILLI_W'(MILLI_PER_TOKEN);
    end else if (blk_ms_r != '0) begin
      upd_entry.blk_active = 1'b1;
      upd_entry.blk_end    = now_r + {{(TIME_W-MILLI_W){1'b0}}, blk_ms_r};
    end
  end

  // Update totals and load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      out_allowed_r   <= 1'b0;
      allowed_total_r <= '0;
      refused_total_r <= '0;
    end else if (cmd.upd_en) begin
      out_valid_r   <= 1'b1;
      out_allowed_r <= admit;
      if (admit && (allowed_total_r != '1)) begin
        allowed_total_r <= allowed_total_r + 1'b1;
      end
      if (!admit && (refused_total_r != '1)) begin
        refused_total_r <= refused_total_r + 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1-2*COUNT_W){1'b0}},
                       refused_total_r, allowed_total_r, out_allowed_r};

endmodule
